// ===== rtl/ang_pkg.sv =====
package ang_pkg;

  // field widths
  localparam int SAMPLE_BITS   = 24;
  localparam int MAX_LOOKAHEAD = 256;
  localparam int THR_W         = 23;
  localparam int COEF_W        = 24;
  localparam int HOLD_W        = 20;
  localparam int LA_W          = 9;
  localparam int GAIN_W        = 17;
  localparam int CHG_W         = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  // fixed point
  localparam int COEF_BITS = 24;
  localparam int ENV_FRAC  = 6;
  localparam int DIV_SH    = 16 - ENV_FRAC;
  localparam int NUM_LO    = GAIN_W - DIV_SH;
  localparam int Y_W       = SAMPLE_BITS + 2;
  localparam int S_W       = SAMPLE_BITS + 3;
  localparam int ENV_W     = Y_W + ENV_FRAC;
  localparam int CMP_W     = ((Y_W > THR_W + 1) ? Y_W : THR_W + 1) + 1;
  localparam int MA_W      = ENV_W + 1;
  localparam int MB_W      = COEF_W + 2;
  localparam int P_W       = MA_W + MB_W;
  localparam int POS_W     = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LEN_W     = POS_W + 1;
  localparam int CNT_W     = $clog2(GAIN_W);
  localparam int LO_IDX_W  = (NUM_LO > 1) ? $clog2(NUM_LO) : 1;

  localparam int COEF_HALF = 1 << (COEF_BITS - 1);
  localparam int GAIN_HALF = 1 << 15;

  localparam logic [COEF_W:0]       COEF_ONE     = {1'b1, {COEF_W{1'b0}}};
  localparam logic [GAIN_W-1:0]     GAIN_ONE     = {1'b1, {(GAIN_W-1){1'b0}}};
  // gain*100 < 65536 holds exactly for gain <= 655
  localparam logic [GAIN_W-1:0]     LOW_GAIN_LIM = GAIN_W'(656);
  localparam logic [MB_W-1:0]       CLOSE_MUL    = MB_W'(100);
  localparam logic signed [P_W-1:0] Y_MAX_P = {{(P_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
  localparam logic signed [P_W-1:0] Y_MIN_P = {{(P_W-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}};

  localparam logic [COEF_W-1:0] ATTACK_DEFAULT  = COEF_W'(376155);
  localparam logic [COEF_W-1:0] RELEASE_DEFAULT = COEF_W'(7607);

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(838861);
  localparam logic [THR_W-1:0]  HYSTERESIS_RST = THR_W'(167772);
  localparam logic [COEF_W-1:0] ALPHA_RST      = COEF_W'(16588120);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_HYSTERESIS = 3'd1,
    CFG_ATTACK     = 3'd2,
    CFG_RELEASE    = 3'd3,
    CFG_HOLD       = 3'd4,
    CFG_HPF_ALPHA  = 3'd5,
    CFG_LOOKAHEAD  = 3'd6
  } cfg_idx_t;

  typedef enum logic [CHG_W-1:0] {
    CHG_NONE  = 2'd0,
    CHG_OPEN  = 2'd1,
    CHG_CLOSE = 2'd2
  } chg_t;

  // datapath operations, one per microcode step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_HPF_SUM,
    OP_HPF_MUL,
    OP_HPF_RND,
    OP_MAG,
    OP_CMP,
    OP_ATK_DIFF,
    OP_ATK_MUL,
    OP_ATK_UPD,
    OP_HOLD,
    OP_REL_MUL,
    OP_REL_UPD,
    OP_CLS_MUL,
    OP_CLS_TST,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN,
    OP_OUT_MUL,
    OP_OUT_RND,
    OP_DLY_RD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NOT_ABOVE,
    JC_HOLD_NZ,
    JC_SAT,
    JC_CNT_NZ
  } jc_t;

  typedef enum logic [1:0] {
    WT_NONE,
    WT_IN,
    WT_OUT
  } wt_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE = 5'd0;
  localparam pc_t PC_HOLD = 5'd9;
  localparam pc_t PC_DIV0 = 5'd14;
  localparam pc_t PC_DIVS = 5'd15;
  localparam pc_t PC_GSET = 5'd16;

  typedef struct packed {
    op_t op;
    wt_t wt;
    jc_t jc;
    pc_t tgt;
  } uword_t;

  function automatic uword_t uw(op_t op, wt_t wt, jc_t jc, pc_t tgt);
    uword_t w;
    w.op  = op;
    w.wt  = wt;
    w.jc  = jc;
    w.tgt = tgt;
    return w;
  endfunction

  // microprogram
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    case (pc)
      5'd0:    w = uw(OP_LOAD,     WT_IN,   JC_NONE,      PC_IDLE);
      5'd1:    w = uw(OP_HPF_SUM,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd2:    w = uw(OP_HPF_MUL,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd3:    w = uw(OP_HPF_RND,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd4:    w = uw(OP_MAG,      WT_NONE, JC_NONE,      PC_IDLE);
      5'd5:    w = uw(OP_CMP,      WT_NONE, JC_NOT_ABOVE, PC_HOLD);
      5'd6:    w = uw(OP_ATK_DIFF, WT_NONE, JC_NONE,      PC_IDLE);
      5'd7:    w = uw(OP_ATK_MUL,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd8:    w = uw(OP_ATK_UPD,  WT_NONE, JC_ALWAYS,    PC_DIV0);
      5'd9:    w = uw(OP_HOLD,     WT_NONE, JC_HOLD_NZ,   PC_DIV0);
      5'd10:   w = uw(OP_REL_MUL,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd11:   w = uw(OP_REL_UPD,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd12:   w = uw(OP_CLS_MUL,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd13:   w = uw(OP_CLS_TST,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd14:   w = uw(OP_DIV_INIT, WT_NONE, JC_SAT,       PC_GSET);
      5'd15:   w = uw(OP_DIV_STEP, WT_NONE, JC_CNT_NZ,    PC_DIVS);
      5'd16:   w = uw(OP_GAIN,     WT_NONE, JC_NONE,      PC_IDLE);
      5'd17:   w = uw(OP_OUT_MUL,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd18:   w = uw(OP_OUT_RND,  WT_NONE, JC_NONE,      PC_IDLE);
      5'd19:   w = uw(OP_DLY_RD,   WT_NONE, JC_NONE,      PC_IDLE);
      5'd20:   w = uw(OP_EMIT,     WT_OUT,  JC_ALWAYS,    PC_IDLE);
      default: w = uw(OP_NOP,      WT_NONE, JC_ALWAYS,    PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/audio_noise_gate_unit.sv =====
// channel   direction  handshake               payload
// in_       input      in_valid / in_stall     in_sample_in
// out_      output     out_valid / out_stall   out_sample_out, out_gain, out_gate_is_open,
//                                              out_gate_change, out_low_gain
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a sample runs the hold, attack or release path, then the 17-step restoring gain divider,
// skipped when the gain saturates; once the result loads, the sequencer goes back to
// its first step for the next sample. rst_n is synchronous; the configuration, sequencer,
// gate-state and output-valid registers take their defaults; the delay line reads as zero.
// a finished result sits in the output register while the next sample is accepted;
// the sequencer waits at its last step only if that register is still stalled.
module audio_noise_gate_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ang_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ang_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic [ang_pkg::GAIN_W-1:0]          out_gain,
  output logic                                out_gate_is_open,
  output logic [ang_pkg::CHG_W-1:0]           out_gate_change,
  output logic                                out_low_gain,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ang_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ang_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ang_pkg::*;

  // configuration
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [THR_W-1:0]  hyst_r, hyst_nxt;
  logic [COEF_W-1:0] atk_r, atk_nxt;
  logic [COEF_W-1:0] rel_r, rel_nxt;
  logic [HOLD_W-1:0] holdcfg_r, holdcfg_nxt;
  logic [COEF_W-1:0] alpha_r, alpha_nxt;
  logic [LA_W-1:0]   la_r, la_nxt;

  // sequencer
  pc_t    pc_r, pc_nxt;
  uword_t uwd;
  logic   go;
  logic   cond;
  logic   busy;
  logic   in_fire;

  // gate state
  logic signed [SAMPLE_BITS-1:0] xl_r, xl_nxt;
  logic signed [Y_W-1:0]         yl_r, yl_nxt;
  logic [ENV_W-1:0]              env_r, env_nxt;
  logic                          gate_r, gate_nxt;
  logic [HOLD_W-1:0]             hold_r, hold_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;

  // working registers
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic signed [S_W-1:0]         sum_r, sum_nxt;
  logic signed [P_W-1:0]         prod_r, prod_nxt;
  logic [Y_W-1:0]                mag_r, mag_nxt;
  logic [ENV_W-1:0]              diff_r, diff_nxt;
  logic                          dneg_r, dneg_nxt;
  chg_t                          chg_r, chg_nxt;
  logic [THR_W-1:0]              rem_r, rem_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [GAIN_W-1:0]             q_r, q_nxt;
  logic                          sat_r, sat_nxt;
  logic [GAIN_W-1:0]             g_r, g_nxt;
  logic signed [SAMPLE_BITS-1:0] gated_r, gated_nxt;

  // output register
  logic                          ov_r, ov_nxt;
  logic signed [SAMPLE_BITS-1:0] osmp_r, osmp_nxt;
  logic [GAIN_W-1:0]             ogain_r, ogain_nxt;
  logic                          oopen_r, oopen_nxt;
  chg_t                          ochg_r, ochg_nxt;
  logic                          olow_r, olow_nxt;

  // delay line
  logic [SAMPLE_BITS-1:0]        dly_mem [MAX_LOOKAHEAD];
  logic [MAX_LOOKAHEAD-1:0]      dly_vld_r;
  logic [SAMPLE_BITS-1:0]        rd_r;
  logic                          rdv_r;
  logic                          mem_we;
  logic                          mem_re;

  // combinational helpers
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [P_W-1:0]   rbias;
  logic signed [P_W-1:0]   rsum;
  logic signed [P_W-1:0]   rsh;
  logic signed [CMP_W-1:0] lim;
  logic                    above;
  logic [ENV_W-1:0]        target;
  logic [COEF_W-1:0]       a_eff;
  logic [COEF_W-1:0]       r_eff;
  logic [COEF_W:0]         rel_mul;
  logic [THR_W-1:0]        div;
  logic [ENV_W-NUM_LO-1:0] env_hi;
  logic [NUM_LO-1:0]       env_lo;
  logic                    nbit;
  logic [THR_W:0]          rem2;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        pinc;

  assign cfg_ready = 1'b1;
  assign uwd       = ucode(pc_r);
  assign in_stall  = (uwd.wt != WT_IN);
  assign in_fire   = in_valid && !in_stall;
  assign busy      = ov_r && out_stall;

  assign out_valid        = ov_r;
  assign out_sample_out   = osmp_r;
  assign out_gain         = ogain_r;
  assign out_gate_is_open = oopen_r;
  assign out_gate_change  = ochg_r;
  assign out_low_gain     = olow_r;

  always_comb begin
    a_eff   = (atk_r != '0) ? atk_r : ATTACK_DEFAULT;
    r_eff   = (rel_r != '0) ? rel_r : RELEASE_DEFAULT;
    rel_mul = COEF_ONE - {1'b0, r_eff};
    div     = (thr_r != '0) ? thr_r : THR_W'(1);
    env_hi  = env_r[ENV_W-1:NUM_LO];
    env_lo  = env_r[NUM_LO-1:0];
    target  = ENV_W'(mag_r) << ENV_FRAC;
    // open gate lowers the limit, closed gate raises it
    if (gate_r) begin
      lim = $signed(CMP_W'(thr_r)) - $signed(CMP_W'(hyst_r));
    end else begin
      lim = $signed(CMP_W'(thr_r)) + $signed(CMP_W'(hyst_r));
    end
    above = $signed({1'b0, CMP_W'(mag_r)}) > $signed({lim[CMP_W-1], lim});
    if (32'(la_r) > 32'(MAX_LOOKAHEAD)) begin
      len = LEN_W'(MAX_LOOKAHEAD);
    end else begin
      len = LEN_W'(la_r);
    end
    pinc = LEN_W'(pos_r) + LEN_W'(1);
    // dividend is env << 10: its low bits below env are zero
    if (cnt_r >= CNT_W'(DIV_SH)) begin
      nbit = env_lo[LO_IDX_W'(cnt_r - CNT_W'(DIV_SH))];
    end else begin
      nbit = 1'b0;
    end
    rem2 = {rem_r, nbit};
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uwd.op)
      OP_HPF_MUL: begin
        mul_a = MA_W'(sum_r);
        mul_b = $signed(MB_W'(alpha_r));
      end
      OP_ATK_MUL: begin
        mul_a = $signed({1'b0, diff_r});
        mul_b = $signed(MB_W'(a_eff));
      end
      OP_REL_MUL: begin
        mul_a = $signed({1'b0, env_r});
        mul_b = $signed(MB_W'(rel_mul));
      end
      OP_CLS_MUL: begin
        mul_a = $signed({1'b0, env_r});
        mul_b = $signed(CLOSE_MUL);
      end
      OP_OUT_MUL: begin
        mul_a = MA_W'(x_r);
        mul_b = $signed(MB_W'(g_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding to nearest, ties away from zero
  always_comb begin
    if (uwd.op == OP_OUT_RND) begin
      rbias = prod_r[P_W-1] ? P_W'(GAIN_HALF - 1) : P_W'(GAIN_HALF);
      rsum  = prod_r + rbias;
      rsh   = rsum >>> 16;
    end else begin
      rbias = prod_r[P_W-1] ? P_W'(COEF_HALF - 1) : P_W'(COEF_HALF);
      rsum  = prod_r + rbias;
      rsh   = rsum >>> COEF_BITS;
    end
  end

  // sequencer next step
  always_comb begin
    case (uwd.wt)
      WT_IN:   go = in_fire;
      WT_OUT:  go = !busy;
      default: go = 1'b1;
    endcase
    case (uwd.jc)
      JC_ALWAYS:    cond = 1'b1;
      JC_NOT_ABOVE: cond = !above;
      JC_HOLD_NZ:   cond = (hold_r != '0);
      JC_SAT:       cond = (env_hi >= (ENV_W-NUM_LO)'(div));
      JC_CNT_NZ:    cond = (cnt_r != '0);
      default:      cond = 1'b0;
    endcase
    if (!go) begin
      pc_nxt = pc_r;
    end else if (cond) begin
      pc_nxt = uwd.tgt;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // datapath
  always_comb begin
    xl_nxt    = xl_r;
    yl_nxt    = yl_r;
    env_nxt   = env_r;
    gate_nxt  = gate_r;
    hold_nxt  = hold_r;
    pos_nxt   = pos_r;
    x_nxt     = x_r;
    sum_nxt   = sum_r;
    prod_nxt  = prod_r;
    mag_nxt   = mag_r;
    diff_nxt  = diff_r;
    dneg_nxt  = dneg_r;
    chg_nxt   = chg_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    q_nxt     = q_r;
    sat_nxt   = sat_r;
    g_nxt     = g_r;
    gated_nxt = gated_r;
    osmp_nxt  = osmp_r;
    ogain_nxt = ogain_r;
    oopen_nxt = oopen_r;
    ochg_nxt  = ochg_r;
    olow_nxt  = olow_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    ov_nxt    = (ov_r && !out_stall) ? 1'b0 : ov_r;

    if (go) begin
      case (uwd.op)
        OP_LOAD: begin
          x_nxt   = in_sample_in;
          chg_nxt = CHG_NONE;
        end
        OP_HPF_SUM: begin
          sum_nxt = S_W'(yl_r) + S_W'(x_r) - S_W'(xl_r);
          xl_nxt  = x_r;
        end
        OP_HPF_MUL, OP_ATK_MUL, OP_REL_MUL, OP_CLS_MUL, OP_OUT_MUL: begin
          prod_nxt = mul_a * mul_b;
        end
        OP_HPF_RND: begin
          if (rsh > Y_MAX_P) begin
            yl_nxt = Y_W'(Y_MAX_P);
          end else if (rsh < Y_MIN_P) begin
            yl_nxt = Y_W'(Y_MIN_P);
          end else begin
            yl_nxt = Y_W'(rsh);
          end
        end
        OP_MAG: begin
          mag_nxt = yl_r[Y_W-1] ? $unsigned(-yl_r) : $unsigned(yl_r);
        end
        OP_ATK_DIFF: begin
          if (target >= env_r) begin
            diff_nxt = target - env_r;
            dneg_nxt = 1'b0;
          end else begin
            diff_nxt = env_r - target;
            dneg_nxt = 1'b1;
          end
          hold_nxt = holdcfg_r;
          if (!gate_r) begin
            gate_nxt = 1'b1;
            chg_nxt  = CHG_OPEN;
          end
        end
        OP_ATK_UPD: begin
          if (dneg_r) begin
            env_nxt = env_r - rsum[COEF_BITS +: ENV_W];
          end else begin
            env_nxt = env_r + rsum[COEF_BITS +: ENV_W];
          end
        end
        OP_HOLD: begin
          if (hold_r != '0) begin
            hold_nxt = hold_r - HOLD_W'(1);
          end
        end
        OP_REL_UPD: begin
          env_nxt = prod_r[COEF_BITS +: ENV_W];
        end
        OP_CLS_TST: begin
          // close once 100*env < 64*threshold
          if (gate_r && (prod_r < $signed(P_W'({thr_r, {ENV_FRAC{1'b0}}})))) begin
            gate_nxt = 1'b0;
            chg_nxt  = CHG_CLOSE;
          end
        end
        OP_DIV_INIT: begin
          sat_nxt = (env_hi >= (ENV_W-NUM_LO)'(div));
          rem_nxt = THR_W'(env_hi);
          cnt_nxt = CNT_W'(GAIN_W - 1);
          q_nxt   = '0;
        end
        OP_DIV_STEP: begin
          if (rem2 >= (THR_W+1)'(div)) begin
            rem_nxt = THR_W'(rem2 - (THR_W+1)'(div));
            q_nxt   = {q_r[GAIN_W-2:0], 1'b1};
          end else begin
            rem_nxt = THR_W'(rem2);
            q_nxt   = {q_r[GAIN_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        OP_GAIN: begin
          if (sat_r || (q_r > GAIN_ONE)) begin
            g_nxt = GAIN_ONE;
          end else begin
            g_nxt = q_r;
          end
        end
        OP_OUT_RND: begin
          gated_nxt = SAMPLE_BITS'(rsh);
          // length may have shrunk since the last sample
          if ((len != '0) && (LEN_W'(pos_r) >= len)) begin
            pos_nxt = '0;
          end
        end
        OP_DLY_RD: begin
          mem_re = 1'b1;
        end
        OP_EMIT: begin
          if (len != '0) begin
            mem_we   = 1'b1;
            osmp_nxt = rdv_r ? $signed(rd_r) : '0;
            pos_nxt  = (pinc == len) ? '0 : POS_W'(pinc);
          end else begin
            osmp_nxt = gated_r;
          end
          ogain_nxt = g_r;
          oopen_nxt = gate_r;
          ochg_nxt  = chg_r;
          olow_nxt  = (g_r < LOW_GAIN_LIM);
          ov_nxt    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // configuration writes
  always_comb begin
    thr_nxt     = thr_r;
    hyst_nxt    = hyst_r;
    atk_nxt     = atk_r;
    rel_nxt     = rel_r;
    holdcfg_nxt = holdcfg_r;
    alpha_nxt   = alpha_r;
    la_nxt      = la_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:  thr_nxt     = cfg_data[THR_W-1:0];
        CFG_HYSTERESIS: hyst_nxt    = cfg_data[THR_W-1:0];
        CFG_ATTACK:     atk_nxt     = cfg_data[COEF_W-1:0];
        CFG_RELEASE:    rel_nxt     = cfg_data[COEF_W-1:0];
        CFG_HOLD:       holdcfg_nxt = cfg_data[HOLD_W-1:0];
        CFG_HPF_ALPHA:  alpha_nxt   = cfg_data[COEF_W-1:0];
        CFG_LOOKAHEAD:  la_nxt      = cfg_data[LA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RST;
      hyst_r    <= HYSTERESIS_RST;
      atk_r     <= ATTACK_DEFAULT;
      rel_r     <= RELEASE_DEFAULT;
      holdcfg_r <= '0;
      alpha_r   <= ALPHA_RST;
      la_r      <= '0;
      pc_r      <= PC_IDLE;
      ov_r      <= 1'b0;
      xl_r      <= '0;
      yl_r      <= '0;
      env_r     <= '0;
      gate_r    <= 1'b0;
      hold_r    <= '0;
      pos_r     <= '0;
    end else begin
      thr_r     <= thr_nxt;
      hyst_r    <= hyst_nxt;
      atk_r     <= atk_nxt;
      rel_r     <= rel_nxt;
      holdcfg_r <= holdcfg_nxt;
      alpha_r   <= alpha_nxt;
      la_r      <= la_nxt;
      pc_r      <= pc_nxt;
      ov_r      <= ov_nxt;
      xl_r      <= xl_nxt;
      yl_r      <= yl_nxt;
      env_r     <= env_nxt;
      gate_r    <= gate_nxt;
      hold_r    <= hold_nxt;
      pos_r     <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    sum_r   <= sum_nxt;
    prod_r  <= prod_nxt;
    mag_r   <= mag_nxt;
    diff_r  <= diff_nxt;
    dneg_r  <= dneg_nxt;
    chg_r   <= chg_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    q_r     <= q_nxt;
    sat_r   <= sat_nxt;
    g_r     <= g_nxt;
    gated_r <= gated_nxt;
    osmp_r  <= osmp_nxt;
    ogain_r <= ogain_nxt;
    oopen_r <= oopen_nxt;
    ochg_r  <= ochg_nxt;
    olow_r  <= olow_nxt;
  end

  // delay line storage, entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else if (mem_we) begin
      dly_vld_r[pos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dly_mem[pos_r] <= gated_r;
    end
    if (mem_re) begin
      rd_r  <= dly_mem[pos_r];
      rdv_r <= dly_vld_r[pos_r];
    end
  end

endmodule

// ===== verif/tb_audio_noise_gate_unit.sv =====
module tb_audio_noise_gate_unit;
  import ang_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 100;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam longint Y_LIM = longint'(1) << (SAMPLE_BITS + 1);

  typedef struct {
    logic [THR_W-1:0]  thr;
    logic [THR_W-1:0]  hys;
    logic [COEF_W-1:0] atk;
    logic [COEF_W-1:0] rel;
    logic [HOLD_W-1:0] hold;
    logic [COEF_W-1:0] alpha;
    logic [LA_W-1:0]   la;
  } gate_cfg_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [GAIN_W-1:0]             gain;
    logic                          is_open;
    chg_t                          change;
    logic                          low;
  } gate_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic [GAIN_W-1:0]             out_gain;
  logic                          out_gate_is_open;
  logic [CHG_W-1:0]              out_gate_change;
  logic                          out_low_gain;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  audio_noise_gate_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_gain         (out_gain),
    .out_gate_is_open (out_gate_is_open),
    .out_gate_change  (out_gate_change),
    .out_low_gain     (out_low_gain),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // gate model state
  gate_cfg_t mcfg;
  longint    hp_x, hp_y, env, hold_cnt;
  logic      gate_open;
  longint    dly_mem [MAX_LOOKAHEAD];
  int        dly_pos;

  gate_result_t pending_results[$];
  int send_pct = 0;
  int recv_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int n_errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_opens = 0;
  int n_closes = 0;
  int n_settings = 0;
  int cycle_cnt = 0;

  function automatic longint round_shift(input longint p, input int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    if (p < 0) return -((-p + half) >>> sh);
    return (p + half) >>> sh;
  endfunction

  function automatic void model_reset();
    mcfg.thr   = THRESHOLD_RST;
    mcfg.hys   = HYSTERESIS_RST;
    mcfg.atk   = ATTACK_DEFAULT;
    mcfg.rel   = RELEASE_DEFAULT;
    mcfg.hold  = '0;
    mcfg.alpha = ALPHA_RST;
    mcfg.la    = '0;
    hp_x = 0;
    hp_y = 0;
    env = 0;
    hold_cnt = 0;
    gate_open = 1'b0;
    dly_pos = 0;
    foreach (dly_mem[i]) dly_mem[i] = 0;
  endfunction

  function automatic gate_result_t gate_predict(input logic signed [SAMPLE_BITS-1:0] smp);
    gate_result_t r;
    longint x, s, y, mag, tgt, coef, g, gated, outv, thr, hys;
    int len;
    logic above;
    x = smp;
    thr = longint'(mcfg.thr);
    hys = longint'(mcfg.hys);
    // sidechain high-pass
    s = hp_y + x - hp_x;
    y = round_shift(s * longint'(mcfg.alpha), COEF_BITS);
    if (y > Y_LIM - 1) y = Y_LIM - 1;
    if (y < -Y_LIM) y = -Y_LIM;
    hp_x = x;
    hp_y = y;
    mag = (y < 0) ? -y : y;
    above = gate_open ? (mag > thr - hys) : (mag > thr + hys);
    r.change = CHG_NONE;
    if (above) begin
      coef = (mcfg.atk != 0) ? longint'(mcfg.atk) : longint'(ATTACK_DEFAULT);
      tgt = mag << ENV_FRAC;
      if (tgt >= env) env = env + (((tgt - env) * coef + COEF_HALF) >> COEF_BITS);
      else env = env - (((env - tgt) * coef + COEF_HALF) >> COEF_BITS);
      hold_cnt = longint'(mcfg.hold);
      if (!gate_open) begin
        gate_open = 1'b1;
        r.change = CHG_OPEN;
        n_opens++;
      end
    end else if (hold_cnt > 0) begin
      hold_cnt--;
    end else begin
      coef = (mcfg.rel != 0) ? longint'(mcfg.rel) : longint'(RELEASE_DEFAULT);
      env = (env * ((longint'(1) << COEF_BITS) - coef)) >> COEF_BITS;
      if (gate_open && env * 100 < (thr << ENV_FRAC)) begin
        gate_open = 1'b0;
        r.change = CHG_CLOSE;
        n_closes++;
      end
    end
    // zero threshold divides by one
    g = (env << (16 - ENV_FRAC)) / ((thr != 0) ? thr : 1);
    if (g > longint'(GAIN_ONE)) g = longint'(GAIN_ONE);
    gated = round_shift(x * g, 16);
    outv = gated;
    len = (mcfg.la > MAX_LOOKAHEAD) ? MAX_LOOKAHEAD : int'(mcfg.la);
    if (len > 0) begin
      if (dly_pos >= len) dly_pos = 0;
      outv = dly_mem[dly_pos];
      dly_mem[dly_pos] = gated;
      dly_pos = (dly_pos + 1) % len;
    end
    r.smp = outv[SAMPLE_BITS-1:0];
    r.gain = g[GAIN_W-1:0];
    r.is_open = gate_open;
    r.low = (g * 100 < longint'(GAIN_ONE));
    return r;
  endfunction

  function automatic gate_cfg_t rand_cfg();
    gate_cfg_t c;
    case ($urandom_range(3))
      0: c.thr = 1;
      1: c.thr = {THR_W{1'b1}};
      2: c.thr = THR_W'($urandom_range(1, 1 << 20));
      default: c.thr = THR_W'($urandom);
    endcase
    case ($urandom_range(3))
      0: c.hys = 0;
      1: c.hys = {THR_W{1'b1}};
      2: c.hys = THR_W'($urandom_range(0, 32'(c.thr)));
      default: c.hys = THR_W'($urandom);
    endcase
    case ($urandom_range(2))
      0: c.atk = 0;
      1: c.atk = {COEF_W{1'b1}};
      default: c.atk = COEF_W'($urandom);
    endcase
    case ($urandom_range(2))
      0: c.rel = 0;
      1: c.rel = {COEF_W{1'b1}};
      default: c.rel = COEF_W'($urandom_range(1 << 20, (1 << COEF_W) - 1));
    endcase
    case ($urandom_range(7))
      0, 1, 2: c.hold = 0;
      7: c.hold = {HOLD_W{1'b1}};
      default: c.hold = HOLD_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(2))
      0: c.alpha = 0;
      1: c.alpha = {COEF_W{1'b1}};
      default: c.alpha = COEF_W'($urandom);
    endcase
    case ($urandom_range(4))
      0: c.la = 0;
      1: c.la = 1;
      2: c.la = LA_W'(MAX_LOOKAHEAD);
      3: c.la = {LA_W{1'b1}};
      default: c.la = LA_W'($urandom_range(2, 300));
    endcase
    return c;
  endfunction

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_THRESHOLD:  mcfg.thr   = val[THR_W-1:0];
      CFG_HYSTERESIS: mcfg.hys   = val[THR_W-1:0];
      CFG_ATTACK:     mcfg.atk   = val[COEF_W-1:0];
      CFG_RELEASE:    mcfg.rel   = val[COEF_W-1:0];
      CFG_HOLD:       mcfg.hold  = val[HOLD_W-1:0];
      CFG_HPF_ALPHA:  mcfg.alpha = val[COEF_W-1:0];
      CFG_LOOKAHEAD:  mcfg.la    = val[LA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_gate(input gate_cfg_t c);
    cfg_write(CFG_THRESHOLD, CFG_DATA_W'(c.thr));
    cfg_write(CFG_HYSTERESIS, CFG_DATA_W'(c.hys));
    cfg_write(CFG_ATTACK, CFG_DATA_W'(c.atk));
    cfg_write(CFG_RELEASE, CFG_DATA_W'(c.rel));
    cfg_write(CFG_HOLD, CFG_DATA_W'(c.hold));
    cfg_write(CFG_HPF_ALPHA, CFG_DATA_W'(c.alpha));
    cfg_write(CFG_LOOKAHEAD, CFG_DATA_W'(c.la));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // one input beat, with an optional idle gap first
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] smp);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(gate_predict(smp));
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_extremes();
    send_pct = 24;
    recv_pct = 70;
    push_sample(0);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(SMP_MAX);
    push_sample(-1);
    push_sample(1);
    wait_drained();
  endtask

  // open on a loud burst, hold, release and close; zero attack picks the default
  task automatic test_open_close();
    gate_cfg_t c;
    c.thr = 100000;
    c.hys = 20000;
    c.atk = 0;
    c.rel = {COEF_W{1'b1}};
    c.hold = 2;
    c.alpha = 24'h800000;
    c.la = 0;
    program_gate(c);
    for (int i = 0; i < 4; i++) push_sample((i % 2) ? 24'sd4194304 : -24'sd4194304);
    repeat (10) push_sample(0);
    wait_drained();
  endtask

  // zero threshold, hysteresis above threshold, zero release, oversized lookahead
  task automatic test_special();
    gate_cfg_t c;
    c.thr = 0;
    c.hys = 5000;
    c.atk = {COEF_W{1'b1}};
    c.rel = 0;
    c.hold = 0;
    c.alpha = {COEF_W{1'b1}};
    c.la = {LA_W{1'b1}};
    program_gate(c);
    push_sample(SMP_MAX);
    push_sample(SMP_MIN);
    push_sample(0);
    push_sample(0);
    wait_drained();
    // shorter line, write position goes back to zero as the length shrinks
    c.la = 3;
    program_gate(c);
    push_sample(1000);
    push_sample(-1000);
    wait_drained();
  endtask

  task automatic test_random_phase(input int phase, input int n);
    int cnt;
    int loud;
    int quiet;
    int level;
    logic signed [SAMPLE_BITS-1:0] v;
    cnt = 0;
    send_pct = (phase < 2) ? 24 : (phase < 4) ? 70 : 0;
    recv_pct = (phase < 2) ? 70 : (phase < 4) ? 24 : 0;
    program_gate(rand_cfg());
    while (cnt < n) begin
      if ($urandom_range(9) < 8) begin
        // loud burst at a random level, then a quiet tail
        loud = $urandom_range(1, 12);
        quiet = $urandom_range(1, 20);
        level = $urandom_range(0, 12);
        repeat (loud) begin
          v = SAMPLE_BITS'($urandom);
          push_sample(v >>> level);
          cnt++;
        end
        repeat (quiet) begin
          push_sample(SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256));
          cnt++;
        end
      end else begin
        case ($urandom_range(3))
          0: push_sample(SMP_MAX);
          1: push_sample(SMP_MIN);
          2: push_sample(0);
          default: push_sample(SAMPLE_BITS'($urandom));
        endcase
        cnt++;
      end
    end
    wait_drained();
  endtask

  // receiver holds off long enough that the block backs up into the input
  task automatic test_backpressure();
    send_pct = 0;
    recv_pct = 0;
    hold_req = 500;
    repeat (30) push_sample(SAMPLE_BITS'($urandom));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_errors++;
      if (n_errors <= 10)
        $display("result %0d %s: expected %0d, got %0d", n_results, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    gate_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("result %0d arrived with none expected", n_results);
      end else begin
        want = pending_results.pop_front();
        check_field("sample_out", longint'(want.smp), longint'(out_sample_out));
        check_field("gain", longint'(want.gain), longint'(out_gain));
        check_field("gate_is_open", longint'(want.is_open), longint'(out_gate_is_open));
        check_field("gate_change", longint'(want.change), longint'(out_gate_change));
        check_field("low_gain", longint'(want.low), longint'(out_low_gain));
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_open_close();
    test_special();
    for (int p = 0; p < RAND_PHASES; p++) test_random_phase(p, PHASE_ITEMS);
    test_backpressure();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples in, %0d results checked across %0d register settings",
             n_items, n_results, n_settings);
    $display("gate opened %0d and closed %0d times, %0d mismatches", n_opens, n_closes,
             n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ang_pkg.sv
rtl/audio_noise_gate_unit.sv
verif/tb_audio_noise_gate_unit.sv
